[sv/lmsd_pkg.sv]
package lmsd_pkg;

  localparam int ONE_HIGH_TICKS  = 140;
  localparam int ONE_LOW_TICKS   = 160;
  localparam int ZERO_HIGH_TICKS = 70;
  localparam int ZERO_LOW_TICKS  = 120;
  localparam int ROWS            = 8;
  localparam int COLUMNS         = 8;

  localparam int COLOUR_REGS = 5;
  localparam int COLOUR_W    = 24;
  localparam int TOP_BIT     = 23;
  localparam int CFG_IDX_W   = 8;
  localparam int REG_SEL_W   = $clog2(COLOUR_REGS);
  localparam int PIXELS      = ROWS * COLUMNS;

  typedef logic [COLOUR_W-1:0] colour_t;
  typedef colour_t [COLOUR_REGS-1:0] colour_bank_t;
  typedef logic [5:0] pixel_t;
  typedef logic [4:0] bit_idx_t;
  typedef logic [7:0] tick_t;
  typedef logic [2:0] coord_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } result_t;

  function automatic colour_t colour_reset(input logic [REG_SEL_W-1:0] idx);
    colour_t val;
    case (idx)
      REG_SEL_W'(0): val = 24'h3F0000;
      REG_SEL_W'(1): val = 24'h003F00;
      REG_SEL_W'(2): val = 24'h253F00;
      REG_SEL_W'(3): val = 24'h00003F;
      REG_SEL_W'(4): val = 24'h0C3F00;
      default:       val = '0;
    endcase
    return val;
  endfunction

endpackage

[sv/lmsd_colour_regs.sv]
module lmsd_colour_regs
  import lmsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [COLOUR_W-1:0]  wr_data,
  output colour_bank_t         colours
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COLOUR_REGS; i++) begin
        colours[i] <= colour_reset(REG_SEL_W'(i));
      end
    end else if (wr_en && (wr_index < CFG_IDX_W'(COLOUR_REGS))) begin
      colours[wr_index[REG_SEL_W-1:0]] <= wr_data;
    end
  end

endmodule

[sv/lmsd_bit_engine.sv]
module lmsd_bit_engine
  import lmsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic         start_req,
  input  logic [63:0]  frame,
  input  colour_bank_t colours,
  output result_t      result
);

  logic [63:0] frame_store, frame_store_next;
  pixel_t      pixel_index, pixel_index_next;
  bit_idx_t    bit_index, bit_index_next;
  logic        low_phase, low_phase_next;
  tick_t       tick_count, tick_count_next;
  logic        sending, sending_next;

  logic [63:0] fs;
  pixel_t      pi;
  pixel_t      pi_inc;
  bit_idx_t    bi;
  logic        lp;
  tick_t       tc;
  tick_t       tc_inc;
  tick_t       span;
  coord_t      row;
  coord_t      col;
  logic [5:0]  pos;
  logic        lit;
  logic [31:0] colour;
  logic        bitval;
  logic        active;

  always_comb begin
    active = sending || start_req;
    fs = sending ? frame_store : frame;
    pi = sending ? pixel_index : '0;
    bi = sending ? bit_index : bit_idx_t'(TOP_BIT);
    lp = sending ? low_phase : 1'b0;
    tc = sending ? tick_count : '0;

    row = coord_t'(pi / COLUMNS);
    col = coord_t'(COLUMNS - 1 - (pi % COLUMNS));
    pos = {row, col};
    lit = fs[pos];
    colour = '0;
    if (lit && (row < coord_t'(COLOUR_REGS))) begin
      colour = 32'(colours[row[REG_SEL_W-1:0]]);
    end
    bitval = colour[bi];

    if (lp) begin
      span = bitval ? tick_t'(ONE_LOW_TICKS) : tick_t'(ZERO_LOW_TICKS);
    end else begin
      span = bitval ? tick_t'(ONE_HIGH_TICKS) : tick_t'(ZERO_HIGH_TICKS);
    end

    tc_inc = tc + 8'd1;
    pi_inc = pi + 6'd1;

    frame_store_next = fs;
    pixel_index_next = pi;
    bit_index_next   = bi;
    low_phase_next   = lp;
    tick_count_next  = tc_inc;
    sending_next     = active;
    result.line_level = active && !lp;
    result.busy_res   = active;
    result.frame_done = 1'b0;

    if ((tc_inc >= span) || (tc_inc == '0)) begin
      tick_count_next = '0;
      if (!lp) begin
        low_phase_next = 1'b1;
      end else begin
        low_phase_next = 1'b0;
        if ((bi == '0) || (bi > bit_idx_t'(TOP_BIT))) begin
          bit_index_next   = bit_idx_t'(TOP_BIT);
          pixel_index_next = pi_inc;
          if ((pi_inc == '0) || (7'(pi_inc) >= 7'(PIXELS))) begin
            pixel_index_next  = '0;
            bit_index_next    = '0;
            sending_next      = 1'b0;
            result.frame_done = active;
          end
        end else begin
          bit_index_next = bi - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_store <= '0;
      pixel_index <= '0;
      bit_index   <= '0;
      low_phase   <= 1'b0;
      tick_count  <= '0;
      sending     <= 1'b0;
    end else if (accept && active) begin
      frame_store <= frame_store_next;
      pixel_index <= pixel_index_next;
      bit_index   <= bit_index_next;
      low_phase   <= low_phase_next;
      tick_count  <= tick_count_next;
      sending     <= sending_next;
    end
  end

endmodule

[sv/lmsd_out_reg.sv]
module lmsd_out_reg
  import lmsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  input  logic    take,
  output logic    valid,
  output result_t data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

[sv/led_matrix_serial_driver_core.sv]
// channel  | signals                       | payload
// s_axis   | tvalid tready tdata tuser     | tdata: frame, tuser: start_req
// m_axis   | tvalid tready tdata tlast     | tdata: line_level, busy_res; tlast: frame_done
// cfg      | valid ready index data        | colour register write, always ready
// one item in per cycle unless stalled; each gives one result, offered the cycle after
// the tick state and the result register update in the cycle an item is taken
// rst is synchronous: colours back to defaults, engine idle, result register empty
// a stalled result holds s_axis_tready low until it is taken
module led_matrix_serial_driver_core
  import lmsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,  // [63:0] frame
  input  logic                 s_axis_tuser,  // [0] start_req
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // [0] line_level, [1] busy_res, [7:2] zero
  output logic                 m_axis_tlast,  // frame_done
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOUR_W-1:0]  cfg_data
);

  colour_bank_t colours;
  result_t      result;
  result_t      out_data;
  logic         in_accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  lmsd_colour_regs u_colour_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .colours  (colours)
  );

  lmsd_bit_engine u_bit_engine (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .start_req (s_axis_tuser),
    .frame     (s_axis_tdata),
    .colours   (colours),
    .result    (result)
  );

  lmsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept),
    .load_data (result),
    .take      (m_axis_tready),
    .valid     (m_axis_tvalid),
    .data      (out_data)
  );

  assign m_axis_tdata = {6'b0, out_data.busy_res, out_data.line_level};
  assign m_axis_tlast = out_data.frame_done;

`ifndef ASSERT_OFF
  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[1])
    else $error("frame_done without busy");

  a_idle_pin_low: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[1]) |-> (!m_axis_tdata[0] && !m_axis_tlast))
    else $error("data line driven while idle");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !in_accept)
    else $error("item taken over a stalled result");
`endif

endmodule

[sim/led_matrix_serial_driver_core_tb.sv]
`timescale 1ns / 100ps

module led_matrix_serial_driver_core_tb;
  import lmsd_pkg::*;

  localparam int IDX_ROW0     = 0;
  localparam int IDX_ROW1     = 1;
  localparam int IDX_ROW2     = 2;
  localparam int IDX_ROW3     = 3;
  localparam int IDX_ROW4     = 4;
  localparam int IDX_SPARE    = 5;
  localparam int IDX_TOP      = 255;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 230;
  localparam int TAIL_CYCLES  = 10;
  localparam int MAX_REPORTS  = 10;

  class line_scoreboard;
    colour_bank_t colours;
    logic [63:0]  frame_store;
    pixel_t       pixel;
    bit_idx_t     bit_pos;
    logic         low_phase;
    tick_t        ticks;
    logic         sending;
    result_t      line_levels[$];
    int           errors;

    function new();
      colours     = {24'h0C3F00, 24'h00003F, 24'h253F00, 24'h003F00, 24'h3F0000};
      frame_store = '0;
      pixel       = '0;
      bit_pos     = '0;
      low_phase   = 1'b0;
      ticks       = '0;
      sending     = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(int index, colour_t value);
      if (index < COLOUR_REGS) colours[index] = value;
    endfunction

    // one line tick per accepted item
    function void take_tick(logic start_req, logic [63:0] frame);
      result_t r;
      int      p;
      int      row;
      int      col;
      logic    lit;
      colour_t c;
      logic    bitval;
      int      span;
      logic    done;
      done = 1'b0;
      if (!sending && !start_req) begin
        r = '0;
        line_levels.push_back(r);
        return;
      end
      if (!sending) begin
        frame_store = frame;
        pixel       = '0;
        bit_pos     = bit_idx_t'(TOP_BIT);
        low_phase   = 1'b0;
        ticks       = '0;
        sending     = 1'b1;
      end
      p   = pixel;
      row = (p / COLUMNS) % 8;
      col = (COLUMNS - 1 - p % COLUMNS) % 8;
      lit = frame_store[row * 8 + col];
      c   = '0;
      if (lit && row < COLOUR_REGS) c = colours[row];
      bitval = (bit_pos <= TOP_BIT) ? c[bit_pos] : 1'b0;
      if (low_phase) span = bitval ? ONE_LOW_TICKS : ZERO_LOW_TICKS;
      else span = bitval ? ONE_HIGH_TICKS : ZERO_HIGH_TICKS;
      r.line_level = !low_phase;
      ticks = ticks + tick_t'(1);
      if (int'(ticks) >= span || ticks == 0) begin
        ticks = '0;
        if (!low_phase) begin
          low_phase = 1'b1;
        end else begin
          low_phase = 1'b0;
          if (bit_pos == 0 || bit_pos > TOP_BIT) begin
            bit_pos = bit_idx_t'(TOP_BIT);
            pixel   = pixel + pixel_t'(1);
            if (pixel == 0 || int'(pixel) >= PIXELS) begin
              pixel   = '0;
              bit_pos = '0;
              sending = 1'b0;
              done    = 1'b1;
            end
          end else begin
            bit_pos = bit_pos - bit_idx_t'(1);
          end
        end
      end
      r.busy_res   = 1'b1;
      r.frame_done = done;
      line_levels.push_back(r);
    endfunction

    function void check_line(result_t got);
      result_t want;
      if (line_levels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected line item: pin %b busy %b done %b",
                   got.line_level, got.busy_res, got.frame_done);
        return;
      end
      want = line_levels.pop_front();
      if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
          got.frame_done !== want.frame_done) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("line mismatch: expected pin %b busy %b done %b, got pin %b busy %b done %b",
                   want.line_level, want.busy_res, want.frame_done,
                   got.line_level, got.busy_res, got.frame_done);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  colour_t              cfg_data;

  line_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;
  int quiet_cycles;

  led_matrix_serial_driver_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic send_item(input logic start_req, input logic [63:0] frame);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= start_req;
    s_axis_tdata  <= frame;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_tick(start_req, frame);
  endtask

  task automatic write_reg(input int index, input colour_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(index);
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_colours(input colour_t c0, input colour_t c1, input colour_t c2,
                             input colour_t c3, input colour_t c4);
    write_reg(IDX_ROW0, c0);
    write_reg(IDX_ROW1, c1);
    write_reg(IDX_ROW2, c2);
    write_reg(IDX_ROW3, c3);
    write_reg(IDX_ROW4, c4);
  endtask

  // sender pauses until every line item is back
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.line_levels.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_item(1'($urandom_range(1)), {$urandom, $urandom});
  endtask

  // receiver
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_line('{line_level: m_axis_tdata[0], busy_res: m_axis_tdata[1],
                      frame_done: m_axis_tlast});
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("led_matrix_serial_driver_core_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    sb            = new();
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle ticks, start, requests while busy, reset colours
    send_item(1'b0, '1);
    send_item(1'b0, '0);
    send_item(1'b0, {$urandom, $urandom});
    send_item(1'b1, '1);
    send_item(1'b1, '0);
    send_item(1'b0, '1);
    send_item(1'b1, {$urandom, $urandom});
    send_item(1'b0, '0);
    repeat (8) send_item(1'($urandom_range(1)), {$urandom, $urandom});
    drain();

    write_reg(IDX_SPARE, '1);
    write_reg(IDX_TOP, colour_t'($urandom));
    set_colours('1, '0, '1, '0, colour_t'($urandom));
    tx_idle_pct = 8;
    rx_idle_pct = 80;
    run_random(PHASE_ITEMS);
    drain();

    set_colours('0, '1, colour_t'($urandom), '1, '0);
    tx_idle_pct = 80;
    rx_idle_pct = 8;
    run_random(PHASE_ITEMS);
    drain();

    set_colours(colour_t'($urandom), colour_t'($urandom), colour_t'($urandom),
                colour_t'($urandom), colour_t'($urandom));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left   = HOLD_CYCLES;
    run_random(PHASE_ITEMS);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.line_levels.size() == 0) begin
      $display("led_matrix_serial_driver_core_tb: clean");
    end else begin
      $display("led_matrix_serial_driver_core_tb: errors");
    end
    $finish;
  end

endmodule
